// ===== design/text_cell_command_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Text cell command parser assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_COMMAND_PARSER_ASSERT_SVH
`define TEXT_CELL_COMMAND_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tccp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tccp assertion failed");

`endif

// ===== design/tccp_pkg.sv =====
// ----------------------------------------------------------------------------
// Text cell command parser package
// Shared types, constants and character helpers for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tccp_pkg;

   localparam int unsigned COORD_BITS = 32;
   localparam int unsigned COUNT_BITS = 16;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_KEYWORD = 4'd1,
      PH_PRE_X   = 4'd2,
      PH_X       = 4'd3,
      PH_PRE_Y   = 4'd4,
      PH_Y       = 4'd5,
      PH_TRAIL   = 4'd6,
      PH_INVALID = 4'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SET    = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_TOGGLE = 2'd2
   } kind_type;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NBSP    = 8'hA0;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_S       = 8'h73;
   localparam logic [7:0] CH_C       = 8'h63;
   localparam logic [7:0] CH_T       = 8'h74;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic      is_command;
      kind_type  command_kind;
      coord_type cell_x;
      coord_type cell_y;
      count_type bytes_consumed;
      logic      last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE || b == CH_NBSP;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic coord_type add_digit(input coord_type acc, input logic [7:0] b);
      return (acc << 3) + (acc << 1) + coord_type'(b[3:0]);
   endfunction

   function automatic logic [2:0] keyword_length(input kind_type kind);
      logic [2:0] len;
      unique case (kind)
         KIND_CLEAR:  len = 3'd6;
         KIND_TOGGLE: len = 3'd7;
         default:     len = 3'd4;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] keyword_char(input kind_type kind, input logic [2:0] pos);
      logic [7:0] ch;
      unique case (kind)
         KIND_CLEAR: begin
            unique case (pos)
               3'd0:    ch = 8'h63;
               3'd1:    ch = 8'h6C;
               3'd2:    ch = 8'h65;
               3'd3:    ch = 8'h61;
               3'd4:    ch = 8'h72;
               3'd5:    ch = CH_SPACE;
               default: ch = 8'h00;
            endcase
         end
         KIND_TOGGLE: begin
            unique case (pos)
               3'd0:    ch = 8'h74;
               3'd1:    ch = 8'h6F;
               3'd2:    ch = 8'h67;
               3'd3:    ch = 8'h67;
               3'd4:    ch = 8'h6C;
               3'd5:    ch = 8'h65;
               3'd6:    ch = CH_SPACE;
               default: ch = 8'h00;
            endcase
         end
         default: begin
            unique case (pos)
               3'd0:    ch = 8'h73;
               3'd1:    ch = 8'h65;
               3'd2:    ch = 8'h74;
               3'd3:    ch = CH_SPACE;
               default: ch = 8'h00;
            endcase
         end
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== design/tccp_input_reg.sv =====
// ----------------------------------------------------------------------------
// Text cell command parser input register
// Holds one incoming byte transaction until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tccp_input_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tccp_pkg::req_type in_data,
   output logic                   out_valid,
   output tccp_pkg::req_type      out_data,
   input  wire logic              out_take
);
   import tccp_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         data_in  = in_data;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ===== design/tccp_parser.sv =====
// ----------------------------------------------------------------------------
// Text cell command parser core
// Parse state and per-byte update; produces up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tccp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire tccp_pkg::req_type data,
   output tccp_pkg::result_pair_type results
);
   import tccp_pkg::*;

   phase_type  phase_ff, phase_in;
   kind_type   kind_ff, kind_in;
   logic [2:0] pos_ff, pos_in;
   coord_type  x_ff, x_in;
   coord_type  y_ff, y_in;
   count_type  counter_ff, counter_in;
   logic       stopped_ff, stopped_in;
   count_type  frozen_ff, frozen_in;

   logic       [7:0] b;
   logic       eob;
   logic       emit;
   logic       [2:0] pos_next;
   result_type cmd_result;
   result_type done_result;

   always_comb begin
      b          = data.text_byte;
      eob        = data.end_of_buffer;
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      pos_in     = pos_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      counter_in = counter_ff;
      stopped_in = stopped_ff;
      frozen_in  = frozen_ff;
      emit       = 1'b0;
      pos_next   = pos_ff + 3'd1;

      if (counter_ff != '1) begin
         counter_in = counter_ff + count_type'(1);
      end

      if (!stopped_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!is_space(b)) begin
                  if (b == CH_S || b == CH_C || b == CH_T) begin
                     kind_in  = (b == CH_S) ? KIND_SET : (b == CH_C) ? KIND_CLEAR : KIND_TOGGLE;
                     pos_in   = 3'd1;
                     phase_in = PH_KEYWORD;
                  end else begin
                     phase_in = PH_INVALID;
                  end
               end
            end
            PH_KEYWORD: begin
               if (b == keyword_char(kind_ff, pos_ff)) begin
                  pos_in = pos_next;
                  if (pos_next >= keyword_length(kind_ff)) begin
                     phase_in = PH_PRE_X;
                  end
               end else if (b == CH_NEWLINE) begin
                  stopped_in = 1'b1;
                  frozen_in  = counter_ff;
               end else begin
                  phase_in = PH_INVALID;
               end
            end
            PH_PRE_X: begin
               if (!is_space(b)) begin
                  if (is_digit(b)) begin
                     x_in     = add_digit('0, b);
                     phase_in = PH_X;
                  end else begin
                     x_in     = '0;
                     y_in     = '0;
                     emit     = 1'b1;
                     phase_in = PH_TRAIL;
                  end
               end
            end
            PH_X: begin
               if (is_digit(b)) begin
                  x_in = add_digit(x_ff, b);
               end else if (is_space(b)) begin
                  phase_in = PH_PRE_Y;
               end else begin
                  y_in     = '0;
                  emit     = 1'b1;
                  phase_in = PH_TRAIL;
               end
            end
            PH_PRE_Y: begin
               if (!is_space(b)) begin
                  if (is_digit(b)) begin
                     y_in     = add_digit('0, b);
                     phase_in = PH_Y;
                  end else begin
                     y_in     = '0;
                     emit     = 1'b1;
                     phase_in = PH_TRAIL;
                  end
               end
            end
            PH_Y: begin
               if (is_digit(b)) begin
                  y_in = add_digit(y_ff, b);
               end else begin
                  emit     = 1'b1;
                  phase_in = (b == CH_NEWLINE) ? PH_IDLE : PH_TRAIL;
               end
            end
            PH_TRAIL: begin
               if (b == CH_NEWLINE) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_INVALID: begin
               if (b == CH_NEWLINE) begin
                  stopped_in = 1'b1;
                  frozen_in  = counter_ff;
               end
            end
            default: begin
               if (b == CH_NEWLINE) begin
                  stopped_in = 1'b1;
                  frozen_in  = counter_ff;
               end
            end
         endcase
         // A number Y cut short by the end of the buffer still completes the command.
         if (eob && !emit && !stopped_in && phase_in == PH_Y) begin
            emit = 1'b1;
         end
      end

      cmd_result.is_command     = 1'b1;
      cmd_result.command_kind   = kind_in;
      cmd_result.cell_x         = x_in;
      cmd_result.cell_y         = y_in;
      cmd_result.bytes_consumed = '0;
      cmd_result.last_of_run    = !eob;

      done_result.is_command     = 1'b0;
      done_result.command_kind   = KIND_SET;
      done_result.cell_x         = '0;
      done_result.cell_y         = '0;
      done_result.bytes_consumed = stopped_in ? frozen_in : counter_in;
      done_result.last_of_run    = 1'b1;

      results.count  = {1'b0, emit} + {1'b0, eob};
      results.first  = emit ? cmd_result : done_result;
      results.second = done_result;

      if (eob) begin
         phase_in   = PH_IDLE;
         kind_in    = KIND_SET;
         pos_in     = '0;
         x_in       = '0;
         y_in       = '0;
         counter_in = '0;
         stopped_in = 1'b0;
         frozen_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         kind_ff    <= KIND_SET;
         pos_ff     <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         counter_ff <= '0;
         stopped_ff <= 1'b0;
         frozen_ff  <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         pos_ff     <= pos_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         counter_ff <= counter_in;
         stopped_ff <= stopped_in;
         frozen_ff  <= frozen_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/tccp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Text cell command parser result queue
// Small register queue taking up to two results per cycle while it has room, giving one when read.
// ----------------------------------------------------------------------------
`default_nettype none

module tccp_result_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire tccp_pkg::result_pair_type push_data,
   output logic                           has_room,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output tccp_pkg::result_type           out_data
);
   import tccp_pkg::*;

   localparam int unsigned FILL_BITS = FIFO_PTR_BITS + 1;

   result_type               entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [1:0]               push_count;
   logic                     pop;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_second;

   assign push_count    = push ? push_data.count : 2'd0;
   assign pop           = out_valid && out_ready;
   assign out_valid     = fill_ff != '0;
   assign out_data      = entries_ff[rd_ptr_ff];
   assign has_room      = fill_ff <= FILL_BITS'(FIFO_DEPTH - 2);
   assign wr_ptr_second = wr_ptr_ff + FIFO_PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      fill_in   = fill_ff + FILL_BITS'(push_count) - FILL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_ptr_second] <= push_data.second;
      end
   end

endmodule

`default_nettype wire

// ===== design/text_cell_command_parser.sv =====
// ----------------------------------------------------------------------------
// Text cell command parser
// Parses set, clear and toggle cell commands from a byte stream.
//
//   Channel  Prefix  Direction  Carries
//   request  req_    in         one text byte and its end-of-buffer mark
//   response rsp_    out        one cell command or one end-of-buffer report
//
// One byte is accepted per cycle while the result queue has room, bounded by
// the per-byte parse update; its results leave through the result queue.
// A byte that ends a command and the buffer together yields two transactions.
// Bytes keep flowing while the four-entry result queue has two free slots.
// Synchronous reset clears all parse state at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_command_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_text_byte,
   input  wire logic                        req_end_of_buffer,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_is_command,
   output logic [1:0]                       rsp_command_kind,
   output logic [tccp_pkg::COORD_BITS-1:0]  rsp_cell_x,
   output logic [tccp_pkg::COORD_BITS-1:0]  rsp_cell_y,
   output logic [tccp_pkg::COUNT_BITS-1:0]  rsp_bytes_consumed,
   output logic                             rsp_last_of_run
);
   import tccp_pkg::*;

   req_type         req_data;
   req_type         held_data;
   logic            held_valid;
   logic            fire;
   logic            has_room;
   result_pair_type results;
   result_type      rsp_data;

   assign req_data.text_byte     = req_text_byte;
   assign req_data.end_of_buffer = req_end_of_buffer;
   assign fire                   = held_valid && has_room;

   tccp_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (held_valid),
      .out_data  (held_data),
      .out_take  (fire)
   );

   tccp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .data    (held_data),
      .results (results)
   );

   tccp_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (results),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_is_command     = rsp_data.is_command;
   assign rsp_command_kind   = rsp_data.command_kind;
   assign rsp_cell_x         = rsp_data.cell_x;
   assign rsp_cell_y         = rsp_data.cell_y;
   assign rsp_bytes_consumed = rsp_data.bytes_consumed;
   assign rsp_last_of_run    = rsp_data.last_of_run;

endmodule

`default_nettype wire

// ===== design/tccp_checker.sv =====
// ----------------------------------------------------------------------------
// Text cell command parser port checker
// Checks response transactions seen at the top-level ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_cell_command_parser_assert.svh"

module tccp_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_is_command,
   input wire logic [1:0]                      rsp_command_kind,
   input wire logic [tccp_pkg::COORD_BITS-1:0] rsp_cell_x,
   input wire logic [tccp_pkg::COORD_BITS-1:0] rsp_cell_y,
   input wire logic [tccp_pkg::COUNT_BITS-1:0] rsp_bytes_consumed,
   input wire logic                            rsp_last_of_run
);
   import tccp_pkg::*;

   logic                                  rsp_stalled;
   logic                                  cmd_not_last;
   logic                                  rsp_command;
   logic                                  rsp_done;
   logic                                  done_fields_ok;
   logic [2*COORD_BITS+COUNT_BITS+3:0]    rsp_payload;

   assign rsp_stalled    = rsp_valid && !rsp_ready;
   assign cmd_not_last   = rsp_valid && rsp_ready && rsp_is_command && !rsp_last_of_run;
   assign rsp_command    = rsp_valid && rsp_is_command;
   assign rsp_done       = rsp_valid && !rsp_is_command;
   assign done_fields_ok = rsp_last_of_run && rsp_command_kind == KIND_SET
                           && rsp_cell_x == '0 && rsp_cell_y == '0;
   assign rsp_payload    = {rsp_is_command, rsp_command_kind, rsp_cell_x, rsp_cell_y,
                            rsp_bytes_consumed, rsp_last_of_run};

   `TCCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))
   `TCCP_ASSERT_NOW(a_done_fields, clock, reset, rsp_done, done_fields_ok)
   `TCCP_ASSERT_NOW(a_cmd_no_count, clock, reset, rsp_command, rsp_bytes_consumed == '0)
   `TCCP_ASSERT_NEXT(a_cmd_then_done, clock, reset, cmd_not_last, rsp_done)

endmodule

bind text_cell_command_parser tccp_checker u_tccp_checker (.*);

`default_nettype wire

// ===== tb/sv/text_cell_command_parser_tb.sv =====
// ----------------------------------------------------------------------------
// Text cell command parser testbench
// Feeds directed and random text buffers through the request
// channel with bursty timing, predicts every command and done report, and
// checks each response transaction against the prediction while the
// response side stalls on its own pattern and once holds off for a long time.
// ----------------------------------------------------------------------------
module text_cell_command_parser_tb;
   import tccp_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_BYTES   = 240;
   localparam int HOLD_CYCLES    = 250;
   localparam int HOLD_TRIGGER   = 12;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte     = 8'h00;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic       rsp_is_command;
   logic [1:0] rsp_command_kind;
   coord_type  rsp_cell_x;
   coord_type  rsp_cell_y;
   count_type  rsp_bytes_consumed;
   logic       rsp_last_of_run;

   text_cell_command_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_byte      (req_text_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_command     (rsp_is_command),
      .rsp_command_kind   (rsp_command_kind),
      .rsp_cell_x         (rsp_cell_x),
      .rsp_cell_y         (rsp_cell_y),
      .rsp_bytes_consumed (rsp_bytes_consumed),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   string      keyword_text [3] = '{"set ", "clear ", "toggle "};
   logic [7:0] blank_set [7]    = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'hA0};

   req_type    text_stream [$];
   logic [7:0] draft_text [$];
   result_type awaited_commands [$];

   phase_type  parse_state   = PH_IDLE;
   kind_type   cur_kind      = KIND_SET;
   logic [2:0] kw_index      = '0;
   coord_type  x_value       = '0;
   coord_type  y_value       = '0;
   count_type  seen_bytes    = '0;
   count_type  frozen_offset = '0;
   logic       line_stopped  = 1'b0;

   int         mismatch_count = 0;
   int         results_seen   = 0;
   int         cycle_count    = 0;
   int         burst_left     = 0;
   int         gap_left       = 0;
   int         hold_left      = 0;
   int         stall_mode     = 0;
   int         mode_left      = 0;
   logic       hold_done      = 1'b0;
   req_type    next_item;
   result_type want;

   function automatic logic blank_byte(input logic [7:0] b);
      return (b >= 8'h09 && b <= 8'h0D) || b == CH_SPACE || b == CH_NBSP;
   endfunction

   function automatic logic decimal_byte(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic coord_type append_digit(input coord_type acc, input logic [7:0] b);
      return acc * 32'd10 + coord_type'(b - CH_ZERO);
   endfunction

   function automatic void clear_parse_state();
      parse_state   = PH_IDLE;
      cur_kind      = KIND_SET;
      kw_index      = '0;
      x_value       = '0;
      y_value       = '0;
      seen_bytes    = '0;
      frozen_offset = '0;
      line_stopped  = 1'b0;
   endfunction

   task automatic parse_text_byte(input logic [7:0] b, input logic eob);
      count_type  offset;
      logic       emit;
      result_type r;
      offset = seen_bytes;
      emit   = 1'b0;
      if (seen_bytes != '1) seen_bytes = seen_bytes + 1'b1;
      if (!line_stopped) begin
         case (parse_state)
            PH_IDLE: begin
               if (!blank_byte(b)) begin
                  if (b == CH_S || b == CH_C || b == CH_T) begin
                     cur_kind = (b == CH_S) ? KIND_SET : (b == CH_C) ? KIND_CLEAR : KIND_TOGGLE;
                     kw_index = 3'd1;
                     parse_state = PH_KEYWORD;
                  end else begin
                     parse_state = PH_INVALID;
                  end
               end
            end
            PH_KEYWORD: begin
               if (b == keyword_text[cur_kind][kw_index]) begin
                  kw_index = kw_index + 3'd1;
                  if (kw_index == keyword_text[cur_kind].len()) parse_state = PH_PRE_X;
               end else if (b == CH_NEWLINE) begin
                  line_stopped  = 1'b1;
                  frozen_offset = offset;
               end else begin
                  parse_state = PH_INVALID;
               end
            end
            PH_PRE_X: begin
               if (!blank_byte(b)) begin
                  if (decimal_byte(b)) begin
                     x_value = append_digit('0, b);
                     parse_state = PH_X;
                  end else begin
                     x_value = '0;
                     y_value = '0;
                     emit = 1'b1;
                     parse_state = PH_TRAIL;
                  end
               end
            end
            PH_X: begin
               if (decimal_byte(b)) begin
                  x_value = append_digit(x_value, b);
               end else if (blank_byte(b)) begin
                  parse_state = PH_PRE_Y;
               end else begin
                  y_value = '0;
                  emit = 1'b1;
                  parse_state = PH_TRAIL;
               end
            end
            PH_PRE_Y: begin
               if (!blank_byte(b)) begin
                  if (decimal_byte(b)) begin
                     y_value = append_digit('0, b);
                     parse_state = PH_Y;
                  end else begin
                     y_value = '0;
                     emit = 1'b1;
                     parse_state = PH_TRAIL;
                  end
               end
            end
            PH_Y: begin
               if (decimal_byte(b)) begin
                  y_value = append_digit(y_value, b);
               end else begin
                  emit = 1'b1;
                  parse_state = (b == CH_NEWLINE) ? PH_IDLE : PH_TRAIL;
               end
            end
            PH_TRAIL: begin
               if (b == CH_NEWLINE) parse_state = PH_IDLE;
            end
            default: begin
               if (b == CH_NEWLINE) begin
                  line_stopped  = 1'b1;
                  frozen_offset = offset;
               end
            end
         endcase
         // A Y value cut short by the end of the buffer still yields its command.
         if (eob && !emit && !line_stopped && parse_state == PH_Y) emit = 1'b1;
      end
      if (emit) begin
         r.is_command     = 1'b1;
         r.command_kind   = cur_kind;
         r.cell_x         = x_value;
         r.cell_y         = y_value;
         r.bytes_consumed = '0;
         r.last_of_run    = !eob;
         awaited_commands.push_back(r);
      end
      if (eob) begin
         r.is_command     = 1'b0;
         r.command_kind   = KIND_SET;
         r.cell_x         = '0;
         r.cell_y         = '0;
         r.bytes_consumed = line_stopped ? frozen_offset : seen_bytes;
         r.last_of_run    = 1'b1;
         awaited_commands.push_back(r);
         clear_parse_state();
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s got 0x%0h, wanted 0x%0h", name, got, exp_val));
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic eob);
      req_type item;
      item.text_byte     = b;
      item.end_of_buffer = eob;
      text_stream.push_back(item);
   endtask

   task automatic queue_text(input string s, input logic closes);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], closes && i == s.len() - 1);
   endtask

   function automatic logic [7:0] random_blank();
      return blank_set[$urandom_range(0, 6)];
   endfunction

   task automatic draft_word(input string s);
      for (int i = 0; i < s.len(); i++) draft_text.push_back(s[i]);
   endtask

   task automatic draft_number();
      int digits;
      digits = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
      repeat (digits) draft_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic build_random_buffer();
      int    roll;
      int    pick;
      int    cut;
      string word;
      draft_text.delete();
      repeat ($urandom_range(1, 5)) begin
         roll = $urandom_range(0, 9);
         word = keyword_text[$urandom_range(0, 2)];
         if (roll < 7) begin
            repeat ($urandom_range(0, 2)) draft_text.push_back(random_blank());
            draft_word(word);
            repeat ($urandom_range(0, 2)) draft_text.push_back(random_blank());
            if ($urandom_range(0, 9) != 0) draft_number();
            repeat ($urandom_range(1, 2)) draft_text.push_back(random_blank());
            if ($urandom_range(0, 9) != 0) draft_number();
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 4)) draft_text.push_back(8'($urandom_range(0, 255)));
         end else if (roll < 9) begin
            pick = $urandom_range(0, word.len() - 1);
            for (int i = 0; i < word.len(); i++)
               draft_text.push_back((i == pick) ? 8'($urandom_range(0, 255)) : word[i]);
            draft_word(" 1 2");
         end else begin
            repeat ($urandom_range(1, 8)) draft_text.push_back(8'($urandom_range(0, 255)));
         end
         draft_text.push_back(CH_NEWLINE);
      end
      if ($urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, draft_text.size());
         while (draft_text.size() > cut) void'(draft_text.pop_back());
      end
      foreach (draft_text[i]) queue_byte(draft_text[i], i == draft_text.size() - 1);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** text_cell_command_parser: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid         <= 1'b0;
         req_text_byte     <= 8'h00;
         req_end_of_buffer <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
         clear_parse_state();
      end else begin
         if (req_valid && req_ready) parse_text_byte(req_text_byte, req_end_of_buffer);
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || text_stream.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_item = text_stream.pop_front();
               req_valid         <= 1'b1;
               req_text_byte     <= next_item.text_byte;
               req_end_of_buffer <= next_item.end_of_buffer;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(4, 48);
                  gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= HOLD_TRIGGER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(8, 64);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (mode_left % 4) != 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (awaited_commands.size() == 0) begin
            report_mismatch("response transaction with nothing awaited");
         end else begin
            want = awaited_commands.pop_front();
            check_field("is_command", rsp_is_command, want.is_command);
            check_field("command_kind", rsp_command_kind, want.command_kind);
            check_field("cell_x", rsp_cell_x, want.cell_x);
            check_field("cell_y", rsp_cell_y, want.cell_y);
            check_field("bytes_consumed", rsp_bytes_consumed, want.bytes_consumed);
            check_field("last_of_run", rsp_last_of_run, want.last_of_run);
         end
      end
   end

   initial begin
      int base;
      queue_text(" \t set 0 0\nclear 4294967295", 1'b0);
      queue_byte(CH_NBSP, 1'b0);
      queue_text("4294967295 xx\ntoggle 4294967296 12345678901\n", 1'b1);
      queue_text("set x\nclear 7 y\ntoggle 5z\nset \n", 1'b1);
      queue_text("set 1 2\nbogus 3 4\nset 5 6\n", 1'b1);
      queue_text("clea\nset 1 1\n", 1'b1);
      queue_text("toggle 12", 1'b1);
      queue_text("set 3 ", 1'b1);
      queue_text("set 3 4", 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(CH_NEWLINE, 1'b1);

      base = text_stream.size();
      while (text_stream.size() - base < RANDOM_BYTES) build_random_buffer();

      queue_text("set 1 2\nq\n", 1'b0);
      queue_byte(CH_SPACE, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (text_stream.size() != 0 || req_valid) @(posedge clock);
      @(posedge clock);
      while (awaited_commands.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** text_cell_command_parser: PASSED **");
      end else begin
         $display("** text_cell_command_parser: FAILED **");
      end
      $finish;
   end

endmodule
